// ===== sv/rscb_pkg.sv =====
// Shared types, register codes and constants for the RLE sprite clip blitter.
package rscb_pkg;

   // Largest surface dimension honored by the clip logic.
   localparam int MAX_SURFACE_DIM = 1024;

   // Signed width of surface coordinates: 11-bit signed origin plus 16-bit bitmap offset.
   localparam int COORD_W = 18;

   localparam logic [7:0] CTRL_SKIP = 8'h80;
   localparam logic [7:0] NIBBLE_HI = 8'hF0;
   localparam logic [7:0] NIBBLE_LO = 8'h0F;
   localparam logic [15:0] PREFIX_WIDTH = 16'h0002;

   typedef enum logic [2:0] {
      CSR_DEST_X         = 3'd0,
      CSR_DEST_Y         = 3'd1,
      CSR_SURFACE_WIDTH  = 3'd2,
      CSR_SURFACE_HEIGHT = 3'd3,
      CSR_BLIT_MODE      = 3'd4,
      CSR_COLOR_SHIFT    = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_COPY   = 2'd0,
      MODE_SHADOW = 2'd1,
      MODE_SHIFT  = 2'd2,
      MODE_UNUSED = 2'd3
   } blit_mode_type;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      logic [7:0] stream_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [9:0] pixel_x;
      logic [9:0] pixel_y;
      logic [7:0] pixel_value;
      logic       darken;
   } rsp_type;

   typedef struct packed {
      logic signed [10:0] dest_x;
      logic signed [10:0] dest_y;
      logic [10:0]        surface_width;
      logic [10:0]        surface_height;
      blit_mode_type      blit_mode;
      logic signed [4:0]  color_shift;
   } cfg_type;

endpackage

// ===== sv/rscb_csr.sv =====
// Configuration register file of the RLE sprite clip blitter.
module rscb_csr
   import rscb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [10:0] csr_data,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DEST_X:         cfg_in.dest_x = csr_data;
            CSR_DEST_Y:         cfg_in.dest_y = csr_data;
            CSR_SURFACE_WIDTH:  cfg_in.surface_width = csr_data;
            CSR_SURFACE_HEIGHT: cfg_in.surface_height = csr_data;
            CSR_BLIT_MODE:      cfg_in.blit_mode = blit_mode_type'(csr_data[1:0]);
            CSR_COLOR_SHIFT:    cfg_in.color_shift = csr_data[4:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_x <= '0;
         cfg_ff.dest_y <= '0;
         cfg_ff.surface_width <= 11'd320;
         cfg_ff.surface_height <= 11'd200;
         cfg_ff.blit_mode <= MODE_COPY;
         cfg_ff.color_shift <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== sv/rscb_decode.sv =====
// Stream parser, run-length counters, per-pixel clip and pixel mode logic.
module rscb_decode
   import rscb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req,
   input  cfg_type cfg,
   output logic    push,
   output rsp_type result
);

   localparam logic [3:0] HDR_PREFIX_CHECK = 4'd3;
   localparam logic [3:0] HDR_LAST         = 4'd7;
   localparam logic [3:0] HDR_DONE         = 4'd8;

   logic [3:0]  header_phase_ff, header_phase_in;
   logic [15:0] bitmap_width_ff, bitmap_width_in;
   logic [15:0] bitmap_height_ff, bitmap_height_in;
   logic [15:0] source_column_ff, source_column_in;
   logic [15:0] source_row_ff, source_row_in;
   logic [7:0]  literal_left_ff, literal_left_in;
   logic        bitmap_done_ff, bitmap_done_in;

   coord_type   clip_w;
   coord_type   clip_h;
   coord_type   pix_x;
   coord_type   pix_y;
   logic        emit;
   logic [16:0] col_sum;
   logic [7:0]  shaded;
   logic signed [5:0] lo_sum;
   logic [3:0]  lo_sat;

   function automatic logic bitmap_over(input logic [15:0] w, input logic [15:0] h,
                                        input logic [15:0] row,
                                        input logic signed [10:0] dy, input coord_type ch);
      coord_type surf_row;
      surf_row = coord_type'(dy) + $signed({2'b00, row});
      return (w == '0) || (row >= h) || (surf_row >= ch);
   endfunction

   assign clip_w = (cfg.surface_width > MAX_SURFACE_DIM) ? coord_type'(MAX_SURFACE_DIM)
                                                         : $signed({7'd0, cfg.surface_width});
   assign clip_h = (cfg.surface_height > MAX_SURFACE_DIM) ? coord_type'(MAX_SURFACE_DIM)
                                                          : $signed({7'd0, cfg.surface_height});

   always_comb begin
      header_phase_in  = header_phase_ff;
      bitmap_width_in  = bitmap_width_ff;
      bitmap_height_in = bitmap_height_ff;
      source_column_in = source_column_ff;
      source_row_in    = source_row_ff;
      literal_left_in  = literal_left_ff;
      bitmap_done_in   = bitmap_done_ff;
      emit    = 1'b0;
      col_sum = '0;
      pix_x   = coord_type'(cfg.dest_x) + $signed({2'b00, source_column_ff});
      pix_y   = coord_type'(cfg.dest_y) + $signed({2'b00, source_row_ff});

      if (req.frame_start) begin
         header_phase_in  = '0;
         bitmap_width_in  = '0;
         bitmap_height_in = '0;
         source_column_in = '0;
         source_row_in    = '0;
         literal_left_in  = '0;
         bitmap_done_in   = 1'b0;
         pix_x = coord_type'(cfg.dest_x);
         pix_y = coord_type'(cfg.dest_y);
      end

      if (!bitmap_done_in) begin
         if (header_phase_in < HDR_DONE) begin
            case (header_phase_in[1:0])
               2'd0:    bitmap_width_in[7:0]   = req.stream_byte;
               2'd1:    bitmap_width_in[15:8]  = req.stream_byte;
               2'd2:    bitmap_height_in[7:0]  = req.stream_byte;
               default: bitmap_height_in[15:8] = req.stream_byte;
            endcase
            if (header_phase_in == HDR_PREFIX_CHECK) begin
               // 02 00 00 00 was the optional prefix: the real header follows
               header_phase_in = (bitmap_width_in == PREFIX_WIDTH && bitmap_height_in == '0)
                                 ? 4'd4 : HDR_DONE;
            end else if (header_phase_in == HDR_LAST) begin
               header_phase_in = HDR_DONE;
            end else begin
               header_phase_in = header_phase_in + 4'd1;
            end
            if (header_phase_in == HDR_DONE)
               bitmap_done_in = bitmap_over(bitmap_width_in, bitmap_height_in, '0,
                                            cfg.dest_y, clip_h);
         end else if (literal_left_in == '0) begin
            if (req.stream_byte[7] && ({9'd0, req.stream_byte[6:0]} <= bitmap_width_in)) begin
               col_sum = {1'b0, source_column_in} + {10'd0, req.stream_byte[6:0]};
               if (col_sum >= {1'b0, bitmap_width_in}) begin
                  col_sum = col_sum - {1'b0, bitmap_width_in};
                  source_row_in = source_row_in + 16'd1;
               end
               source_column_in = col_sum[15:0];
               bitmap_done_in = bitmap_over(bitmap_width_in, bitmap_height_in, source_row_in,
                                            cfg.dest_y, clip_h);
            end else begin
               literal_left_in = req.stream_byte;
            end
         end else begin
            literal_left_in = literal_left_in - 8'd1;
            col_sum = {1'b0, source_column_in} + 17'd1;
            if (col_sum >= {1'b0, bitmap_width_in}) begin
               source_column_in = '0;
               source_row_in = source_row_in + 16'd1;
            end else begin
               source_column_in = col_sum[15:0];
            end
            bitmap_done_in = bitmap_over(bitmap_width_in, bitmap_height_in, source_row_in,
                                         cfg.dest_y, clip_h);
            emit = (pix_x >= 0) && (pix_y >= 0) && (pix_x < clip_w) && (pix_y < clip_h);
         end
      end
   end

   // Color shift: saturate low nibble plus shift to 0..15, never emit zero
   always_comb begin
      lo_sum = $signed({2'b00, req.stream_byte[3:0]}) + 6'(cfg.color_shift);
      if (lo_sum > 6'sd15)
         lo_sat = 4'd15;
      else if (lo_sum < 6'sd0)
         lo_sat = 4'd0;
      else
         lo_sat = lo_sum[3:0];
      shaded = (req.stream_byte & NIBBLE_HI) | ({4'd0, lo_sat} & NIBBLE_LO);
      if (shaded == '0)
         shaded = 8'd1;
   end

   always_comb begin
      push = accept && emit;
      result.pixel_x = pix_x[9:0];
      result.pixel_y = pix_y[9:0];
      case (cfg.blit_mode)
         MODE_SHADOW: begin
            result.pixel_value = '0;
            result.darken = 1'b1;
         end
         MODE_SHIFT: begin
            result.pixel_value = shaded;
            result.darken = 1'b0;
         end
         default: begin
            result.pixel_value = req.stream_byte;
            result.darken = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_phase_ff  <= '0;
         bitmap_width_ff  <= '0;
         bitmap_height_ff <= '0;
         source_column_ff <= '0;
         source_row_ff    <= '0;
         literal_left_ff  <= '0;
         bitmap_done_ff   <= 1'b1;
      end else if (accept) begin
         header_phase_ff  <= header_phase_in;
         bitmap_width_ff  <= bitmap_width_in;
         bitmap_height_ff <= bitmap_height_in;
         source_column_ff <= source_column_in;
         source_row_ff    <= source_row_in;
         literal_left_ff  <= literal_left_in;
         bitmap_done_ff   <= bitmap_done_in;
      end
   end

endmodule

// ===== sv/rscb_out_buf.sv =====
// Output register with skid stage for pixel write requests.
module rscb_out_buf
   import rscb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_data_ff, out_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    pop;

   assign pop = out_valid_ff && !rsp_stall;
   assign full = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_in  = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

`ifndef ASSERT_OFF
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output register");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !skid_valid_ff)
      else $error("request pushed into full output buffer");

   a_skid_kept: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_stall) |=> (skid_valid_ff && $stable(skid_data_ff)))
      else $error("skid entry lost while output stalled");

   a_skid_moves_up: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_stall) |=> (out_valid_ff && out_data_ff == $past(skid_data_ff)))
      else $error("skid entry not forwarded to output register");
`endif

endmodule

// ===== sv/rle_sprite_clip_blitter_top.sv =====
// Top level of the RLE sprite clip blitter.
//
// Usage: sprite stream bytes enter on the req_ channel, one per accepted
// request (req_valid high, req_stall low); frame_start marks the first byte
// of a bitmap. Each literal pixel that lands inside the clip surface yields
// one pixel write request on the rsp_ channel; headers, skips, clipped
// pixels and bytes outside a bitmap yield none.
// Throughput: one byte per cycle while req_stall is low; the parser updates its
// counters and clip compare combinationally between the request and the output
// register that holds each pixel write for the rsp_ channel.
// When the receiver holds rsp_stall, one further pixel write is absorbed in a
// skid stage; req_stall is then high until the receiver takes a write.
// Registers are written on the csr_ channel (index, data); csr_ready is
// always high. Write them only while no request is in flight.
// Reset (synchronous, active high) restores register defaults, empties the
// output buffer and idles the parser until a byte with frame_start.
module rle_sprite_clip_blitter_top
   import rscb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [10:0] csr_data
);

   cfg_type cfg;
   logic    accept;
   logic    push;
   logic    full;
   rsp_type result;

   assign req_stall = full;
   assign accept = req_valid && !full;

   rscb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   rscb_decode u_decode (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cfg    (cfg),
      .push   (push),
      .result (result)
   );

   rscb_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== verif/rscb_checker.sv =====
// Checker for the RLE sprite clip blitter: predicts pixel writes from the bus traffic and compares.
`timescale 1ns / 1ps

module rscb_checker
   import rscb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [10:0] csr_data,
   output int          fail_count,
   output int          pending
);

   cfg_type    blit_cfg;
   logic [3:0] hdr_phase;
   logic [15:0] bm_width;
   logic [15:0] bm_height;
   int         src_col;
   int         src_row;
   logic [7:0] run_left;
   bit         bm_done;

   rsp_type    expected_pixels[$];

   initial begin
      fail_count = 0;
      pending = 0;
   end

   function automatic int clip_limit(input logic [10:0] reg_val);
      return (reg_val < MAX_SURFACE_DIM) ? int'(reg_val) : MAX_SURFACE_DIM;
   endfunction

   function automatic void update_done();
      if (bm_width == 0 || src_row >= bm_height ||
          int'($signed(blit_cfg.dest_y)) + src_row >= clip_limit(blit_cfg.surface_height))
         bm_done = 1'b1;
   endfunction

   // Advances the decoder by one stream byte; returns 1 when a pixel write is due.
   function automatic bit blit_step(input req_type r, output rsp_type px);
      logic [7:0] b;
      int x;
      int y;
      int lo;
      logic [7:0] shaded;
      b = r.stream_byte;
      px = '0;
      if (r.frame_start) begin
         hdr_phase = '0;
         bm_width = '0;
         bm_height = '0;
         src_col = 0;
         src_row = 0;
         run_left = '0;
         bm_done = 1'b0;
      end
      if (bm_done)
         return 1'b0;

      if (hdr_phase < 8) begin
         case (hdr_phase[1:0])
            2'd0: bm_width[7:0] = b;
            2'd1: bm_width[15:8] = b;
            2'd2: bm_height[7:0] = b;
            default: bm_height[15:8] = b;
         endcase
         // width 2, height 0 in the first four bytes means that was the prefix
         if (hdr_phase == 3)
            hdr_phase = (bm_width == PREFIX_WIDTH && bm_height == 0) ? 4'd4 : 4'd8;
         else if (hdr_phase == 7)
            hdr_phase = 4'd8;
         else
            hdr_phase = hdr_phase + 4'd1;
         if (hdr_phase == 8)
            update_done();
         return 1'b0;
      end

      if (run_left == 0) begin
         if (b[7] && int'(b) <= int'(CTRL_SKIP) + int'(bm_width)) begin
            src_col = src_col + int'(b) - int'(CTRL_SKIP);
            if (src_col >= bm_width) begin
               src_col = src_col - int'(bm_width);
               src_row++;
            end
            update_done();
         end else begin
            run_left = b;
         end
         return 1'b0;
      end

      run_left = run_left - 8'd1;
      x = int'($signed(blit_cfg.dest_x)) + src_col;
      y = int'($signed(blit_cfg.dest_y)) + src_row;
      src_col++;
      if (src_col >= bm_width) begin
         src_col = 0;
         src_row++;
      end
      update_done();

      if (x < 0 || y < 0 || x >= clip_limit(blit_cfg.surface_width) ||
          y >= clip_limit(blit_cfg.surface_height))
         return 1'b0;

      px.pixel_x = x[9:0];
      px.pixel_y = y[9:0];
      case (blit_cfg.blit_mode)
         MODE_SHADOW: begin
            px.pixel_value = '0;
            px.darken = 1'b1;
         end
         MODE_SHIFT: begin
            lo = int'(b & NIBBLE_LO) + int'($signed(blit_cfg.color_shift));
            if (lo > 15) lo = 15;
            if (lo < 0) lo = 0;
            shaded = lo[7:0] | (b & NIBBLE_HI);
            px.pixel_value = (shaded == 0) ? 8'd1 : shaded;
         end
         default: px.pixel_value = b;
      endcase
      return 1'b1;
   endfunction

   task automatic report_field(input string name, input int want, input int got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type pix;
      if (reset) begin
         blit_cfg.dest_x = '0;
         blit_cfg.dest_y = '0;
         blit_cfg.surface_width = 11'd320;
         blit_cfg.surface_height = 11'd200;
         blit_cfg.blit_mode = MODE_COPY;
         blit_cfg.color_shift = '0;
         hdr_phase = '0;
         bm_width = '0;
         bm_height = '0;
         src_col = 0;
         src_row = 0;
         run_left = '0;
         bm_done = 1'b1;
         expected_pixels.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DEST_X:         blit_cfg.dest_x = csr_data;
               CSR_DEST_Y:         blit_cfg.dest_y = csr_data;
               CSR_SURFACE_WIDTH:  blit_cfg.surface_width = csr_data;
               CSR_SURFACE_HEIGHT: blit_cfg.surface_height = csr_data;
               CSR_BLIT_MODE:      blit_cfg.blit_mode = blit_mode_type'(csr_data[1:0]);
               CSR_COLOR_SHIFT:    blit_cfg.color_shift = csr_data[4:0];
               default: ;
            endcase
         end
         // compare before pushing: a write never leaves in the cycle its byte enters
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected pixel write, expected none, actual x=%0d y=%0d v=%0d d=%0d",
                        $time, rsp_data.pixel_x, rsp_data.pixel_y, rsp_data.pixel_value,
                        rsp_data.darken);
               fail_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_data.pixel_x !== want.pixel_x)
                  report_field("pixel_x", want.pixel_x, rsp_data.pixel_x);
               if (rsp_data.pixel_y !== want.pixel_y)
                  report_field("pixel_y", want.pixel_y, rsp_data.pixel_y);
               if (rsp_data.pixel_value !== want.pixel_value)
                  report_field("pixel_value", want.pixel_value, rsp_data.pixel_value);
               if (rsp_data.darken !== want.darken)
                  report_field("darken", want.darken, rsp_data.darken);
            end
         end
         if (req_valid && !req_stall) begin
            if (blit_step(req_data, pix))
               expected_pixels.push_back(pix);
         end
      end
      pending = expected_pixels.size();
   end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the RLE sprite clip blitter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
   import rscb_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [10:0] csr_data;

   int fail_count;
   int pending;

   int send_idle_pct = 15;
   int rcv_idle_pct = 60;
   int hold_req = 0;
   int phase_items = 0;
   int quiet_cycles = 0;

   rle_sprite_clip_blitter_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   rscb_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Pixel write receiver: random stall, or a long hold-off when one is requested.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic fs);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{stream_byte: b, frame_start: fs};
      do @(posedge clock); while (req_stall);
      phase_items++;
   endtask

   task automatic csr_write(input csr_index_type idx, input int value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[10:0];
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_config(input int dx, input int dy, input int sw, input int sh,
                               input int mode, input int shift);
      csr_write(CSR_DEST_X, dx);
      csr_write(CSR_DEST_Y, dy);
      csr_write(CSR_SURFACE_WIDTH, sw);
      csr_write(CSR_SURFACE_HEIGHT, sh);
      csr_write(CSR_BLIT_MODE, mode);
      csr_write(CSR_COLOR_SHIFT, shift);
   endtask

   // Stop offering requests until every predicted pixel write has come out.
   task automatic drain_pixels();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [7:0] pixel_byte();
      logic [3:0] nib;
      nib = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return {4'h0, nib};
         2: return {nib, 4'hF};
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_noise();
      int n;
      n = $urandom_range(1, 8);
      repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
   endtask

   // One bitmap: optional prefix, header, then skips and literal runs with random content.
   task automatic send_sprite();
      int w, h, total, covered, abort_at, n, t, k, r, skip_max;
      logic fs;
      r = $urandom_range(0, 39);
      if (r == 0) begin
         w = $urandom_range(250, 300);
         h = 1;
      end else if (r == 1) begin
         w = 1;
         h = $urandom_range(256, 262);
      end else if (r == 2) begin
         w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 9);
         h = (w == 0) ? $urandom_range(0, 5) : 0;
      end else begin
         w = $urandom_range(1, 24);
         h = $urandom_range(1, 12);
      end
      total = w * h;
      // occasionally cut the bitmap short so the next frame start lands mid-bitmap
      abort_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, total) : total;
      fs = 1'b1;
      if ($urandom_range(0, 1)) begin
         send_byte(PREFIX_WIDTH[7:0], 1'b1);
         repeat (3) send_byte(8'h00, 1'b0);
         fs = 1'b0;
      end
      send_byte(w[7:0], fs);
      send_byte(w[15:8], 1'b0);
      send_byte(h[7:0], 1'b0);
      send_byte(h[15:8], 1'b0);
      skip_max = (w < 127) ? w : 127;
      covered = 0;
      while (covered < abort_at) begin
         r = $urandom_range(0, 99);
         if (r < 25) begin
            n = $urandom_range(0, skip_max);
            send_byte(CTRL_SKIP + n[7:0], 1'b0);
            covered += n;
         end else if (r < 30) begin
            send_byte(8'h00, 1'b0);
         end else begin
            // a 0x80+n byte with n past the width is a literal run, not a skip
            if (r < 34 && w < 127)
               t = $urandom_range(129 + w, 255);
            else if (r < 38)
               t = $urandom_range(17, 127);
            else
               t = $urandom_range(1, 16);
            send_byte(t[7:0], 1'b0);
            for (k = 0; k < t; k++)
               send_byte(pixel_byte(), 1'b0);
            covered += t;
         end
      end
   endtask

   initial begin
      int phase;
      int budget;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset config, copy mode
      send_byte(8'h55, 1'b0);                 // idle, ignored
      send_byte(8'h02, 1'b1);                 // prefix
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h03, 1'b0);                 // width 3, height 2
      send_byte(8'h00, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h02, 1'b0);                 // run of two
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);                 // zero-length run
      send_byte(8'h81, 1'b0);                 // skip to row 1
      send_byte(8'h83, 1'b0);                 // skip whole row, bitmap ends
      send_byte(8'h12, 1'b0);                 // past end, ignored
      send_byte(8'h00, 1'b1);                 // empty bitmap, width 0
      send_byte(8'h00, 1'b0);
      send_byte(8'h05, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h01, 1'b1);                 // header cut short by a new frame
      send_byte(8'h00, 1'b0);
      send_byte(8'h02, 1'b1);                 // width 2, height 1
      send_byte(8'h00, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h82, 1'b0);

      for (phase = 0; phase < 10; phase++) begin
         drain_pixels();
         case (phase)
            0: apply_config(-4, -2, 30, 20, MODE_SHIFT, 15);
            1: apply_config(1023, 1023, 1024, 1024, MODE_SHIFT, -16);
            2: apply_config(-1024, -1024, 2047, 2047, MODE_UNUSED, -15);
            3: apply_config(0, 0, 320, 200, MODE_COPY, 0);
            4: apply_config(3, 5, 0, 0, MODE_SHIFT, 7);
            5: apply_config(-5, -3, 64, 48, MODE_SHADOW, -15);
            6: apply_config(-5, -3, 1, 1, MODE_COPY, 0);
            default: apply_config(int'($urandom_range(0, 48)) - 8, int'($urandom_range(0, 30)) - 6,
                                  $urandom_range(1, 64), $urandom_range(1, 40),
                                  $urandom_range(0, 3), $urandom_range(0, 31));
         endcase
         if (phase < 4) begin
            send_idle_pct = 15;
            rcv_idle_pct = 60;
         end else if (phase < 7) begin
            send_idle_pct = 60;
            rcv_idle_pct = 15;
         end else begin
            send_idle_pct = 0;
            rcv_idle_pct = 0;
         end
         // the last sprite of a phase runs past its budget, about a hundred bytes on average
         case (phase)
            1: budget = 50;
            2, 6: budget = 40;
            4: budget = 30;
            7, 8, 9: budget = 100;
            default: budget = 120;
         endcase
         // pixels in rows 0..199 all land here, so a long hold-off backs the block up
         if (phase == 3)
            hold_req = 300;
         phase_items = 0;
         while (phase_items < budget) begin
            if ($urandom_range(0, 9) == 0)
               send_noise();
            else
               send_sprite();
            if ($urandom_range(0, 19) == 0)
               drain_pixels();
         end
      end

      drain_pixels();
      repeat (10) @(negedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
